// ----- hdl/whs64_pkg.sv -----
// shared constants, types and helpers of the word stream hash
package whs64_pkg;

	localparam logic [63:0] SEED_VALUE = 64'he3789eb1a9c372c1;
	localparam logic [63:0] WORD_MUL   = 64'd99194853094755497;
	localparam logic [31:0] WORD_MUL_LO = WORD_MUL[31:0];
	localparam logic [31:0] WORD_MUL_HI = WORD_MUL[63:32];
	localparam logic [63:0] ZERO_MUL   = 64'd28657;
	localparam logic [31:0] FULL_MUL   = 32'd514229;
	localparam logic [31:0] QUAD_MUL   = 32'd9369319;
	localparam logic [31:0] PAIR_MUL   = 32'd433494437;
	localparam logic [31:0] BYTE_MUL   = 32'd2971215073;

	localparam int unsigned ZERO_ROT = 7;
	localparam int unsigned FULL_ROT = 14;
	localparam int unsigned QUAD_ROT = 21;
	localparam int unsigned PAIR_ROT = 28;
	localparam int unsigned BYTE_ROT = 35;

	localparam int unsigned QUEUE_DEPTH = 4;
	localparam int unsigned QUEUE_AW    = $clog2(QUEUE_DEPTH);

	// lane 0 carries a full word or the 4-byte piece, lane 1 the 2-byte
	// piece, lane 2 the single byte
	typedef struct packed {
		logic       last;
		logic       zero_fold;
		logic       full_word;
		logic [2:0] lane_en;
	} whs64_ctl_t;

	typedef struct packed {
		whs64_ctl_t  ctl;
		logic [63:0] x0;
		logic [16:0] x1;
		logic [8:0]  x2;
	} whs64_desc_t;

	function automatic logic [63:0] rotl64(input logic [63:0] v, input int unsigned n);
		return (v << n) | (v >> (64 - n));
	endfunction

endpackage

// ----- hdl/whs64_front.sv -----
// front end: takes words, classifies them into fold lanes, feeds the queue
module whs64_front import whs64_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic [63:0] data_word,
	input  logic [3:0]  valid_bytes,
	input  logic        last,
	input  logic        data_valid,
	output logic        data_stall,
	output logic        push,
	output whs64_desc_t push_desc,
	input  logic        q_full
);

	logic        valid_s1;
	whs64_desc_t desc_s1;
	whs64_desc_t desc_c;
	logic        accept;
	logic        full_word;
	logic        zero_word;
	logic [15:0] pair_bytes;
	logic [7:0]  single_byte;

	assign data_stall = valid_s1 && q_full;
	assign accept     = data_valid && !data_stall;
	assign push       = valid_s1 && !q_full;
	assign push_desc  = desc_s1;

	always_comb begin
		// counts of eight and above fold as a whole word
		full_word = !last || valid_bytes[3];
		zero_word = data_word == 64'd0;
		// pair sits after the quad if there is one
		pair_bytes = valid_bytes[2] ? data_word[47:32] : data_word[15:0];
		// single byte sits at the even offset below the count
		unique case (valid_bytes[2:1])
			2'd0:    single_byte = data_word[7:0];
			2'd1:    single_byte = data_word[23:16];
			2'd2:    single_byte = data_word[39:32];
			default: single_byte = data_word[55:48];
		endcase

		desc_c.ctl.last      = last;
		desc_c.ctl.full_word = full_word;
		desc_c.ctl.zero_fold = full_word && zero_word;
		if (full_word) begin
			desc_c.ctl.lane_en = {2'b00, !zero_word};
			desc_c.x0          = data_word;
		end else begin
			desc_c.ctl.lane_en = {valid_bytes[0], valid_bytes[1], valid_bytes[2]};
			desc_c.x0          = 64'({1'b0, data_word[31:0]} + 33'd1);
		end
		desc_c.x1 = {1'b0, pair_bytes} + 17'd1;
		desc_c.x2 = {1'b0, single_byte} + 9'd1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (push) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			desc_s1 <= desc_c;
		end
	end

endmodule

// ----- hdl/whs64_queue.sv -----
// short fifo of classified words between front and back
module whs64_queue import whs64_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        push,
	input  whs64_desc_t push_desc,
	output logic        full,
	input  logic        pop,
	output logic        valid,
	output whs64_desc_t pop_desc
);

	whs64_desc_t         entry_q [QUEUE_DEPTH];
	logic [QUEUE_AW-1:0] wr_ptr_q;
	logic [QUEUE_AW-1:0] rd_ptr_q;
	logic [QUEUE_AW:0]   count_q;

	assign full     = count_q == (QUEUE_AW + 1)'(QUEUE_DEPTH);
	assign valid    = count_q != '0;
	assign pop_desc = entry_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_desc;
		end
	end

endmodule

// ----- hdl/whs64_back.sv -----
// back end: lane multiply pipeline, running hash and output register
module whs64_back import whs64_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        q_valid,
	input  whs64_desc_t q_desc,
	output logic        pop,
	output logic [63:0] hash_value,
	output logic        hash_valid,
	input  logic        hash_stall
);

	logic adv;

	logic       valid_s1, valid_s2, valid_s3, valid_s4;
	whs64_ctl_t ctl_s1, ctl_s2, ctl_s3, ctl_s4;

	// stage 1: partial products of WORD_MUL * x
	logic [63:0] p0_ll_s1;
	logic [31:0] p0_lh_s1, p0_hl_s1;
	logic [48:0] p1_l_s1;
	logic [31:0] p1_h_s1;
	logic [40:0] p2_l_s1;
	logic [31:0] p2_h_s1;

	// stage 2: rotated lane products
	logic [63:0] a0_c, a1_c, a2_c;
	logic [63:0] rot0_s2, rot1_s2, rot2_s2;

	// stage 3: partial products with the lane multipliers
	logic [31:0] m0_c;
	logic [63:0] t0_lo_s3, t1_lo_s3, t2_lo_s3;
	logic [31:0] t0_hi_s3, t1_hi_s3, t2_hi_s3;

	// stage 4: combined term
	logic [63:0] f0_c, f1_c, f2_c, term_c;
	logic [63:0] term_s4;

	logic [63:0] hash_q;
	logic [63:0] hash_next;
	logic        hash_valid_q;
	logic [63:0] hash_value_q;

	// whole back end freezes while a result waits on a stalled receiver
	assign adv        = !hash_valid_q || !hash_stall;
	assign pop        = q_valid && adv;
	assign hash_valid = hash_valid_q;
	assign hash_value = hash_value_q;

	always_comb begin
		a0_c = p0_ll_s1 + {p0_lh_s1 + p0_hl_s1, 32'd0};
		a1_c = 64'(p1_l_s1) + {p1_h_s1, 32'd0};
		a2_c = 64'(p2_l_s1) + {p2_h_s1, 32'd0};
		m0_c = ctl_s2.full_word ? FULL_MUL : QUAD_MUL;
		f0_c = t0_lo_s3 + {t0_hi_s3, 32'd0};
		f1_c = t1_lo_s3 + {t1_hi_s3, 32'd0};
		f2_c = t2_lo_s3 + {t2_hi_s3, 32'd0};
		term_c = (ctl_s3.lane_en[0] ? f0_c : 64'd0)
			^ (ctl_s3.lane_en[1] ? f1_c : 64'd0)
			^ (ctl_s3.lane_en[2] ? f2_c : 64'd0);
		// the zero word folds the hash into itself, so it stays in the loop
		if (ctl_s4.zero_fold) begin
			hash_next = hash_q ^ 64'(rotl64(hash_q, ZERO_ROT) * ZERO_MUL);
		end else begin
			hash_next = hash_q ^ term_s4;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1     <= 1'b0;
			valid_s2     <= 1'b0;
			valid_s3     <= 1'b0;
			valid_s4     <= 1'b0;
			hash_valid_q <= 1'b0;
			hash_q       <= SEED_VALUE;
		end else if (adv) begin
			valid_s1     <= q_valid;
			valid_s2     <= valid_s1;
			valid_s3     <= valid_s2;
			valid_s4     <= valid_s3;
			hash_valid_q <= valid_s4 && ctl_s4.last;
			if (valid_s4) begin
				hash_q <= ctl_s4.last ? SEED_VALUE : hash_next;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			ctl_s1   <= q_desc.ctl;
			p0_ll_s1 <= 64'(WORD_MUL_LO) * 64'(q_desc.x0[31:0]);
			p0_lh_s1 <= WORD_MUL_LO * q_desc.x0[63:32];
			p0_hl_s1 <= WORD_MUL_HI * q_desc.x0[31:0];
			p1_l_s1  <= 49'(WORD_MUL_LO) * 49'(q_desc.x1);
			p1_h_s1  <= WORD_MUL_HI * 32'(q_desc.x1);
			p2_l_s1  <= 41'(WORD_MUL_LO) * 41'(q_desc.x2);
			p2_h_s1  <= WORD_MUL_HI * 32'(q_desc.x2);

			ctl_s2  <= ctl_s1;
			rot0_s2 <= ctl_s1.full_word ? rotl64(a0_c, FULL_ROT) : rotl64(a0_c, QUAD_ROT);
			rot1_s2 <= rotl64(a1_c, PAIR_ROT);
			rot2_s2 <= rotl64(a2_c, BYTE_ROT);

			ctl_s3   <= ctl_s2;
			t0_lo_s3 <= 64'(rot0_s2[31:0]) * 64'(m0_c);
			t0_hi_s3 <= rot0_s2[63:32] * m0_c;
			t1_lo_s3 <= 64'(rot1_s2[31:0]) * 64'(PAIR_MUL);
			t1_hi_s3 <= rot1_s2[63:32] * PAIR_MUL;
			t2_lo_s3 <= 64'(rot2_s2[31:0]) * 64'(BYTE_MUL);
			t2_hi_s3 <= rot2_s2[63:32] * BYTE_MUL;

			ctl_s4  <= ctl_s3;
			term_s4 <= term_c;

			if (valid_s4 && ctl_s4.last) begin
				hash_value_q <= hash_next;
			end
		end
	end

endmodule

// ----- hdl/word_stream_hash64_top.sv -----
// top level of the 64-bit word stream hash
// A message enters as little-endian 64-bit words on the data channel
// (data_word, valid_bytes, last with data_valid / data_stall). valid_bytes
// is read only on the last word; a count of eight or more folds the whole
// word. One hash_value leaves on the hash channel (hash_valid / hash_stall)
// for every last word, and the running hash then restarts at the seed.
// A transaction completes on a rising edge with valid high and stall low.
// Throughput is one word per cycle while hash_stall is low, zero words
// included: the only hash-dependent step is a small constant multiply in
// the accumulator, all other lane products run ahead in a four-stage
// multiply pipeline. A last word goes from its accepting edge to hash_valid
// through the front register, queue, four multiply stages, accumulator and
// output register.
// A stalled output freezes the back end; the four-entry queue and the front
// register then fill and data_stall rises.
// Reset clears all valid flags and the queue and loads the seed.
module word_stream_hash64_top import whs64_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic [63:0] data_word,
	input  logic [3:0]  valid_bytes,
	input  logic        last,
	input  logic        data_valid,
	output logic        data_stall,
	output logic [63:0] hash_value,
	output logic        hash_valid,
	input  logic        hash_stall
);

	logic        push;
	whs64_desc_t push_desc;
	logic        q_full;
	logic        q_valid;
	logic        pop;
	whs64_desc_t q_desc;

	whs64_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.data_word   (data_word),
		.valid_bytes (valid_bytes),
		.last        (last),
		.data_valid  (data_valid),
		.data_stall  (data_stall),
		.push        (push),
		.push_desc   (push_desc),
		.q_full      (q_full)
	);

	whs64_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_desc (push_desc),
		.full      (q_full),
		.pop       (pop),
		.valid     (q_valid),
		.pop_desc  (q_desc)
	);

	whs64_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.q_valid    (q_valid),
		.q_desc     (q_desc),
		.pop        (pop),
		.hash_value (hash_value),
		.hash_valid (hash_valid),
		.hash_stall (hash_stall)
	);

endmodule

// ----- tb/sv/testbench.sv -----
// self-checking testbench of the 64-bit word stream hash
`timescale 1ns / 1ps

module testbench;

	localparam logic [63:0] START_HASH = 64'he3789eb1a9c372c1;
	localparam logic [63:0] K_WORD     = 64'd99194853094755497;
	localparam logic [63:0] K_ZERO     = 64'd28657;
	localparam logic [63:0] K_FULL     = 64'd514229;
	localparam logic [63:0] K_QUAD     = 64'd9369319;
	localparam logic [63:0] K_PAIR     = 64'd433494437;
	localparam logic [63:0] K_BYTE     = 64'd2971215073;
	localparam int unsigned R_ZERO     = 7;
	localparam int unsigned R_FULL     = 14;
	localparam int unsigned R_QUAD     = 21;
	localparam int unsigned R_PAIR     = 28;
	localparam int unsigned R_BYTE     = 35;
	localparam int unsigned ITEMS      = 1150;
	localparam int unsigned LIMIT      = 400000;
	localparam int unsigned DRAIN      = 12;

	// running hash of the current message and the hashes still owed by the block
	class hash_tracker;
		logic [63:0] running;
		logic [63:0] expected_hashes[$];
		int unsigned errors, words, messages, checked;
		int unsigned fin_empty, fin_short, fin_full, fin_over;

		function new();
			running = START_HASH;
		endfunction

		function logic [63:0] spin_left(logic [63:0] v, int unsigned n);
			return (v << n) | (v >> (64 - n));
		endfunction

		function logic [63:0] absorb_word(logic [63:0] h, logic [63:0] w);
			if (w == 64'd0)
				return h ^ (spin_left(h, R_ZERO) * K_ZERO);
			return h ^ (spin_left(K_WORD * w, R_FULL) * K_FULL);
		endfunction

		function logic [63:0] absorb_chunk(logic [63:0] h, logic [63:0] p, int unsigned r,
				logic [63:0] m);
			return h ^ (spin_left(K_WORD * (p + 64'd1), r) * m);
		endfunction

		function void note_word(logic [63:0] w, logic [3:0] n, logic fin);
			logic [63:0] h;
			int unsigned cnt, at;
			words++;
			if (!fin) begin
				running = absorb_word(running, w);
				return;
			end
			messages++;
			if (n == 0) fin_empty++;
			else if (n < 8) fin_short++;
			else if (n == 8) fin_full++;
			else fin_over++;
			cnt = (n > 8) ? 8 : n;
			h = running;
			at = 0;
			if (cnt == 8) begin
				h = absorb_word(h, w);
			end else begin
				if (at + 4 <= cnt) begin
					h = absorb_chunk(h, (w >> (8 * at)) & 64'hffff_ffff, R_QUAD, K_QUAD);
					at += 4;
				end
				if (at + 2 <= cnt) begin
					h = absorb_chunk(h, (w >> (8 * at)) & 64'hffff, R_PAIR, K_PAIR);
					at += 2;
				end
				if (at + 1 <= cnt)
					h = absorb_chunk(h, (w >> (8 * at)) & 64'hff, R_BYTE, K_BYTE);
			end
			expected_hashes.push_back(h);
			running = START_HASH;
		endfunction

		function void check_hash(logic [63:0] got);
			logic [63:0] want;
			if (expected_hashes.size() == 0) begin
				$error("hash_value: no hash expected, actual %h", got);
				errors++;
				return;
			end
			want = expected_hashes.pop_front();
			checked++;
			if (got !== want) begin
				$error("hash_value: expected %h, actual %h", want, got);
				errors++;
			end
		endfunction

		function int unsigned pending();
			return expected_hashes.size();
		endfunction
	endclass

	logic        clk = 1'b0;
	logic        arst_n;
	logic [63:0] data_word;
	logic [3:0]  valid_bytes;
	logic        last;
	logic        data_valid;
	logic        data_stall;
	logic [63:0] hash_value;
	logic        hash_valid;
	logic        hash_stall = 1'b0;

	hash_tracker book = new();
	int unsigned tx_gap_max = 12;
	int unsigned rx_stall_max = 12;
	int unsigned rx_hold = 0;
	int unsigned cycles = 0;

	word_stream_hash64_top i_dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.data_word   (data_word),
		.valid_bytes (valid_bytes),
		.last        (last),
		.data_valid  (data_valid),
		.data_stall  (data_stall),
		.hash_value  (hash_value),
		.hash_valid  (hash_valid),
		.hash_stall  (hash_stall)
	);

	always #5 clk = ~clk;

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == LIMIT) begin
			$display("[word_stream_hash64_top] ERROR");
			$finish;
		end
	end

	// hash side: check each transaction, then hold stall for a random count
	always @(posedge clk) begin
		if (arst_n && hash_valid && !hash_stall) begin
			book.check_hash(hash_value);
			rx_hold = (rx_stall_max == 0) ? 0 : $urandom_range(rx_stall_max, 0);
			hash_stall <= (rx_hold != 0);
		end else if (rx_hold != 0) begin
			rx_hold = rx_hold - 1;
			hash_stall <= (rx_hold != 0);
		end
	end

	function automatic logic [63:0] pick_word();
		case ($urandom_range(9, 0))
			0: return 64'd0;
			1: return '1;
			2: return 64'd1 << $urandom_range(63, 0);
			default: return {$urandom, $urandom};
		endcase
	endfunction

	function automatic int unsigned pick_limit();
		case ($urandom_range(2, 0))
			0: return 0;
			1: return 3;
			default: return 12;
		endcase
	endfunction

	// called right after a rising edge; returns at the accepting edge
	task automatic send_word(input logic [63:0] w, input logic [3:0] n, input logic fin);
		int unsigned gap;
		gap = (tx_gap_max == 0) ? 0 : $urandom_range(tx_gap_max, 0);
		if (gap != 0) begin
			data_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		data_word   <= w;
		valid_bytes <= n;
		last        <= fin;
		data_valid  <= 1'b1;
		@(posedge clk);
		while (data_stall) @(posedge clk);
		book.note_word(w, n, fin);
	endtask

	initial begin
		int unsigned len;
		logic [3:0] n;
		bit paused;
		paused = 0;
		arst_n      <= 1'b0;
		data_word   <= '0;
		valid_bytes <= '0;
		last        <= 1'b0;
		data_valid  <= 1'b0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: empty final, zero words, all-ones words, every partial count
		send_word('1, 4'd0, 1'b1);
		send_word(64'd0, 4'd15, 1'b0);
		send_word('1, 4'd7, 1'b0);
		send_word(64'd0, 4'd8, 1'b1);
		send_word('1, 4'd8, 1'b1);
		for (int i = 1; i < 8; i++)
			send_word('1, i[3:0], 1'b1);
		send_word(pick_word(), 4'd9, 1'b1);
		send_word(64'h8000_0000_0000_0000, 4'd0, 1'b0);
		send_word({$urandom, $urandom}, 4'd15, 1'b1);
		send_word(64'd0, 4'd0, 1'b0);
		send_word(64'd0, 4'd3, 1'b1);
		send_word(64'h0000_0000_ffff_ffff, 4'd5, 1'b0);
		send_word(64'hffff_ffff_0000_0000, 4'd4, 1'b1);
		send_word({$urandom, $urandom}, 4'd6, 1'b0);
		send_word(64'd0, 4'd0, 1'b1);

		// random messages, idle limits change now and then
		while (book.words < ITEMS) begin
			if ($urandom_range(9, 0) == 0) begin
				tx_gap_max   = pick_limit();
				rx_stall_max = pick_limit();
			end
			if (!paused && book.words >= ITEMS / 2) begin
				paused = 1;
				data_valid <= 1'b0;
				@(posedge clk);
				while (book.pending() != 0) @(posedge clk);
			end
			len = ($urandom_range(15, 0) == 0) ? $urandom_range(24, 9) : $urandom_range(6, 1);
			for (int i = 1; i < len; i++)
				send_word(pick_word(), 4'($urandom_range(15, 0)), 1'b0);
			case ($urandom_range(9, 0))
				0: n = 4'd0;
				1: n = 4'($urandom_range(15, 9));
				default: n = 4'($urandom_range(8, 1));
			endcase
			send_word(pick_word(), n, 1'b1);
		end

		data_valid <= 1'b0;
		while (book.pending() != 0) @(posedge clk);
		repeat (DRAIN) @(posedge clk);

		$display("covered %0d words in %0d messages, %0d hashes checked",
			book.words, book.messages, book.checked);
		$display("final words: %0d empty, %0d partial, %0d full, %0d count above eight",
			book.fin_empty, book.fin_short, book.fin_full, book.fin_over);
		if (book.errors == 0)
			$display("[word_stream_hash64_top] OK");
		else
			$display("[word_stream_hash64_top] ERROR");
		$finish;
	end

endmodule

// ----- filelist.f -----
hdl/whs64_pkg.sv
hdl/whs64_front.sv
hdl/whs64_queue.sv
hdl/whs64_back.sv
hdl/word_stream_hash64_top.sv
tb/sv/testbench.sv
